@@ hw/rtl/jcv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcv_pkg
// Types, codes and small helpers shared by the jersey color vote unit.
// ----------------------------------------------------------------------------
package jcv_pkg;

    // one HSI triple (pixel or jersey reference)
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] inten;
    } jcv_hsi_t;

    // black_mode codes; code 3 behaves like BLACK_NONE
    localparam logic [1:0] BLACK_NONE = 2'd0;
    localparam logic [1:0] BLACK_OWN  = 2'd1;
    localparam logic [1:0] BLACK_OPP  = 2'd2;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_OWN_COLOR    = 3'd0,
        CFG_OPP_COLOR    = 3'd1,
        CFG_BLACK_MODE   = 3'd2,
        CFG_WG_LIMITS    = 3'd3,
        CFG_DARK_LIMITS  = 3'd4,
        CFG_RANGE_LIMITS = 3'd5,
        CFG_NEEDED_COUNT = 3'd6
    } jcv_cfg_idx_t;

    // classifier settings, unpacked from the config registers
    typedef struct packed {
        jcv_hsi_t   own;
        jcv_hsi_t   opp;
        logic [1:0] black_mode;
        logic [7:0] min_white_i;
        logic [7:0] max_white_s;
        logic [7:0] min_green_h;
        logic [7:0] max_green_h;
        logic [7:0] min_green_i;
        logic [7:0] max_black_i;
        logic [7:0] max_dark_i;
        logic [7:0] max_gray_s;
        logic [7:0] range_h;
        logic [7:0] range_s;
        logic [7:0] range_i;
    } jcv_cfg_t;

    // per-pixel counter increments
    typedef struct packed {
        logic white;
        logic teammate;
        logic opponent;
    } jcv_bump_t;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = (a >= b) ? (a - b) : (b - a);
        return r;
    endfunction

    // wrapped hue distance; wrap is 256, or 255 when wrap255 is set
    function automatic logic [8:0] hue_dist(input logic [7:0] a, input logic [7:0] b,
                                            input logic wrap255);
        logic [8:0] d;
        logic [8:0] e;
        d = {1'b0, abs_diff8(a, b)};
        e = (wrap255 ? 9'd255 : 9'd256) - d;
        return (d < e) ? d : e;
    endfunction

endpackage

@@ hw/rtl/jcv_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcv_classify
// Classifies one HSI pixel as white, green, teammate or opponent color.
// ----------------------------------------------------------------------------
module jcv_classify (
    input  jcv_pkg::jcv_hsi_t  pixel,
    input  jcv_pkg::jcv_cfg_t  cfg,
    output jcv_pkg::jcv_bump_t bump
);

    logic             is_white;
    logic             is_green;
    logic             bright;
    logic             dim;
    logic             gray_ok;
    logic [8:0]       rh2;
    logic [8:0]       rh_eff;
    // black-team path
    jcv_pkg::jcv_hsi_t ref_col;
    logic [7:0]       blk_i;
    logic [8:0]       dh;
    logic [7:0]       ds;
    logic [7:0]       di;
    logic             blk_black;
    logic             blk_nonblack;
    // normal path
    logic [8:0]       d_own;
    logic [8:0]       d_opp;
    logic             near_own;
    logic             near_opp;
    logic             norm_tm;
    logic             norm_opp;

    assign is_white = (pixel.inten > cfg.min_white_i) && (pixel.sat < cfg.max_white_s);
    assign is_green = (pixel.hue > cfg.min_green_h) && (pixel.hue < cfg.max_green_h)
                   && (pixel.inten > cfg.min_green_i);
    assign bright   = pixel.inten > cfg.max_black_i;
    assign dim      = pixel.inten < cfg.max_dark_i;
    assign gray_ok  = pixel.sat > cfg.max_gray_s;
    assign rh2      = {cfg.range_h, 1'b0};
    assign rh_eff   = dim ? rh2 : {1'b0, cfg.range_h};

    // reference is the team not in black; blk_i is the black team's intensity
    assign ref_col = (cfg.black_mode == jcv_pkg::BLACK_OWN) ? cfg.opp : cfg.own;
    assign blk_i   = (cfg.black_mode == jcv_pkg::BLACK_OWN) ? cfg.own.inten : cfg.opp.inten;
    assign dh      = jcv_pkg::hue_dist(pixel.hue, ref_col.hue, 1'b1);
    assign ds      = jcv_pkg::abs_diff8(pixel.sat, ref_col.sat);
    assign di      = jcv_pkg::abs_diff8(pixel.inten, blk_i);

    always_comb begin
        blk_black    = 1'b0;
        blk_nonblack = 1'b0;
        if (bright) begin
            if (dim) begin
                blk_nonblack = (dh < rh2) && gray_ok;
                blk_black    = !blk_nonblack;
            end else begin
                blk_nonblack = (dh < {1'b0, cfg.range_h}) && (ds < cfg.range_s) && gray_ok;
            end
        end else begin
            blk_black = di < cfg.range_i;
        end
    end

    assign d_own    = jcv_pkg::hue_dist(pixel.hue, cfg.own.hue, 1'b0);
    assign d_opp    = jcv_pkg::hue_dist(pixel.hue, cfg.opp.hue, 1'b0);
    assign near_own = d_own < rh_eff;
    assign near_opp = d_opp < rh_eff;
    // both near: closer hue wins, tie goes to opponent
    assign norm_tm  = bright && gray_ok && near_own && (!near_opp || (d_own < d_opp));
    assign norm_opp = bright && gray_ok && near_opp && (!near_own || (d_own >= d_opp));

    always_comb begin
        bump = '0;
        if (is_white) begin
            bump.white = 1'b1;
        end else if (is_green) begin
            bump = '0;
        end else if (cfg.black_mode == jcv_pkg::BLACK_OWN) begin
            bump.teammate = blk_black;
            bump.opponent = blk_nonblack;
        end else if (cfg.black_mode == jcv_pkg::BLACK_OPP) begin
            bump.opponent = blk_black;
            bump.teammate = blk_nonblack;
        end else begin
            bump.teammate = norm_tm;
            bump.opponent = norm_opp;
        end
    end

endmodule

@@ hw/rtl/jersey_color_vote_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jersey_color_vote_unit
// Votes on jersey color over one scan row of HSI pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle on the s_ stream and classes it as white, green,
// teammate or opponent color. Three saturating 8-bit counters collect the
// votes. The pixel flagged by s_tlast closes the row: one decision item
// carrying the found flag, the own-team flag and the three totals goes out
// on the m_ stream and the counters restart at zero for the next row.
// Throughput is one pixel per cycle, sustained across row boundaries while a
// result slot is free. A last pixel passes four registers (input, classifier,
// counter/snapshot, result) before its result item is valid on m_. A snapshot
// stage and the result register give two slots of result buffering, so pixels
// keep flowing while a result waits; the input stalls only when both slots are
// full and another last pixel reaches the counters. Configuration must be
// written while the unit is idle.
// ----------------------------------------------------------------------------
module jersey_color_vote_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] hue, [15:8] saturation, [23:16] intensity
    input  logic        s_tuser,    // [0] search_player
    input  logic        s_tlast,    // last_sample

    // decision stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [0] jersey_found, [1] own_team,
                                    // [9:2] opponent_total, [17:10] teammate_total,
                                    // [25:18] white_total, [31:26] zero

    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [23:0] own_color_reg;
    logic [23:0] opp_color_reg;
    logic [1:0]  black_mode_reg;
    logic [39:0] wg_limits_reg;
    logic [23:0] dark_limits_reg;
    logic [23:0] range_limits_reg;
    logic [7:0]  needed_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_color_reg    <= '0;
            opp_color_reg    <= '0;
            black_mode_reg   <= jcv_pkg::BLACK_NONE;
            wg_limits_reg    <= '0;
            dark_limits_reg  <= '0;
            range_limits_reg <= '0;
            needed_count_reg <= 8'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                jcv_pkg::CFG_OWN_COLOR:    own_color_reg    <= cfg_wdata[23:0];
                jcv_pkg::CFG_OPP_COLOR:    opp_color_reg    <= cfg_wdata[23:0];
                jcv_pkg::CFG_BLACK_MODE:   black_mode_reg   <= cfg_wdata[1:0];
                jcv_pkg::CFG_WG_LIMITS:    wg_limits_reg    <= cfg_wdata;
                jcv_pkg::CFG_DARK_LIMITS:  dark_limits_reg  <= cfg_wdata[23:0];
                jcv_pkg::CFG_RANGE_LIMITS: range_limits_reg <= cfg_wdata[23:0];
                jcv_pkg::CFG_NEEDED_COUNT: needed_count_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // register byte fields: first-named byte is the most significant
    jcv_pkg::jcv_cfg_t cfg;
    always_comb begin
        cfg.own.hue     = own_color_reg[23:16];
        cfg.own.sat     = own_color_reg[15:8];
        cfg.own.inten   = own_color_reg[7:0];
        cfg.opp.hue     = opp_color_reg[23:16];
        cfg.opp.sat     = opp_color_reg[15:8];
        cfg.opp.inten   = opp_color_reg[7:0];
        cfg.black_mode  = black_mode_reg;
        cfg.min_white_i = wg_limits_reg[39:32];
        cfg.max_white_s = wg_limits_reg[31:24];
        cfg.min_green_h = wg_limits_reg[23:16];
        cfg.max_green_h = wg_limits_reg[15:8];
        cfg.min_green_i = wg_limits_reg[7:0];
        cfg.max_black_i = dark_limits_reg[23:16];
        cfg.max_dark_i  = dark_limits_reg[15:8];
        cfg.max_gray_s  = dark_limits_reg[7:0];
        cfg.range_h     = range_limits_reg[23:16];
        cfg.range_s     = range_limits_reg[15:8];
        cfg.range_i     = range_limits_reg[7:0];
    end

    // ---------------- flow control ----------------
    // Only last pixels occupy the result slots, so only they can stall.
    logic a_valid_reg;
    logic b_valid_reg;
    logic b_last_reg;
    logic snap_valid_reg;
    logic m_valid_reg;

    logic out_free;
    logic snap_free;
    logic b_ready;
    logic a_ready;
    logic s_fire;
    logic b_fire;
    logic snap_load;

    assign out_free  = !m_valid_reg || m_tready;
    assign snap_free = !snap_valid_reg || out_free;
    assign b_ready   = !b_valid_reg || !b_last_reg || snap_free;
    assign a_ready   = !a_valid_reg || b_ready;
    assign s_tready  = a_ready;
    assign s_fire    = s_tvalid && a_ready;
    assign b_fire    = b_valid_reg && b_ready;
    assign snap_load = snap_valid_reg && out_free;

    // ---------------- stage A: input register ----------------
    jcv_pkg::jcv_hsi_t a_pix_reg;
    logic              a_search_reg;
    logic              a_last_reg;
    logic              a_valid_next;

    assign a_valid_next = s_fire ? 1'b1 : (b_ready ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_pix_reg.hue   <= s_tdata[7:0];
            a_pix_reg.sat   <= s_tdata[15:8];
            a_pix_reg.inten <= s_tdata[23:16];
            a_search_reg    <= s_tuser;
            a_last_reg      <= s_tlast;
        end
    end

    // ---------------- stage B: classification ----------------
    jcv_pkg::jcv_bump_t bump;
    jcv_pkg::jcv_bump_t b_bump_reg;
    logic               b_search_reg;
    logic               a_move;
    logic               b_valid_next;

    jcv_classify u_classify (
        .pixel (a_pix_reg),
        .cfg   (cfg),
        .bump  (bump)
    );

    assign a_move       = a_valid_reg && b_ready;
    assign b_valid_next = a_move ? 1'b1 : (b_ready ? 1'b0 : b_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            if (a_move) begin
                b_last_reg <= a_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_bump_reg   <= bump;
            b_search_reg <= a_search_reg;
        end
    end

    // ---------------- stage C: vote counters and row snapshot ----------------
    logic [7:0] opp_cnt_reg;
    logic [7:0] tm_cnt_reg;
    logic [7:0] wh_cnt_reg;
    logic [7:0] opp_inc;
    logic [7:0] tm_inc;
    logic [7:0] wh_inc;
    logic [7:0] opp_cnt_next;
    logic [7:0] tm_cnt_next;
    logic [7:0] wh_cnt_next;

    // saturate at 255
    assign opp_inc = (b_bump_reg.opponent && (opp_cnt_reg != 8'hFF)) ? opp_cnt_reg + 8'd1
                                                                      : opp_cnt_reg;
    assign tm_inc  = (b_bump_reg.teammate && (tm_cnt_reg != 8'hFF)) ? tm_cnt_reg + 8'd1
                                                                     : tm_cnt_reg;
    assign wh_inc  = (b_bump_reg.white && (wh_cnt_reg != 8'hFF)) ? wh_cnt_reg + 8'd1
                                                                 : wh_cnt_reg;

    always_comb begin
        opp_cnt_next = opp_cnt_reg;
        tm_cnt_next  = tm_cnt_reg;
        wh_cnt_next  = wh_cnt_reg;
        if (b_fire) begin
            if (b_last_reg) begin
                opp_cnt_next = '0;
                tm_cnt_next  = '0;
                wh_cnt_next  = '0;
            end else begin
                opp_cnt_next = opp_inc;
                tm_cnt_next  = tm_inc;
                wh_cnt_next  = wh_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opp_cnt_reg <= '0;
            tm_cnt_reg  <= '0;
            wh_cnt_reg  <= '0;
        end else begin
            opp_cnt_reg <= opp_cnt_next;
            tm_cnt_reg  <= tm_cnt_next;
            wh_cnt_reg  <= wh_cnt_next;
        end
    end

    // snapshot holds the row totals, last pixel included
    logic       row_done;
    logic       snap_valid_next;
    logic [7:0] snap_opp_reg;
    logic [7:0] snap_tm_reg;
    logic [7:0] snap_wh_reg;
    logic       snap_search_reg;

    assign row_done        = b_fire && b_last_reg;
    assign snap_valid_next = row_done ? 1'b1 : (snap_load ? 1'b0 : snap_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_done) begin
            snap_opp_reg    <= opp_inc;
            snap_tm_reg     <= tm_inc;
            snap_wh_reg     <= wh_inc;
            snap_search_reg <= b_search_reg;
        end
    end

    // ---------------- decision ----------------
    logic [7:0]  need;
    logic [7:0]  diff;
    logic        hit;
    logic [10:0] color_x3;
    logic        found;
    logic        own;

    assign need     = (needed_count_reg == 8'd0) ? 8'd1 : needed_count_reg;
    assign diff     = jcv_pkg::abs_diff8(snap_opp_reg, snap_tm_reg);
    assign hit      = ((snap_opp_reg >= need) || (snap_tm_reg >= need))
                   && (diff >= {1'b0, need[7:1]}) && (diff != 8'd0);
    assign color_x3 = 11'd3 * ({3'b000, snap_opp_reg} + {3'b000, snap_tm_reg});

    always_comb begin
        found = 1'b0;
        own   = 1'b0;
        if (snap_search_reg) begin
            // white must not dominate the jersey colors
            found = hit && ({3'b000, snap_wh_reg} <= color_x3);
            own   = found && (snap_tm_reg > snap_opp_reg);
        end else begin
            // black team check only
            found = hit && (((black_mode_reg == jcv_pkg::BLACK_OWN)
                             && (snap_opp_reg < snap_tm_reg))
                         || ((black_mode_reg == jcv_pkg::BLACK_OPP)
                             && (snap_opp_reg > snap_tm_reg)));
        end
    end

    // ---------------- stage D: result register ----------------
    logic        m_valid_next;
    logic [31:0] m_data_reg;

    assign m_valid_next = snap_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_load) begin
            m_data_reg <= {6'd0, snap_wh_reg, snap_tm_reg, snap_opp_reg, own, found};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
